// ===== src/tfd_pkg.sv =====
// Shared types and constants for the trace frame deformatter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tfd_pkg;

   localparam int unsigned PAYLOAD_BYTES = 15;
   localparam int unsigned POS_WIDTH = 4;
   localparam int unsigned AUX_WIDTH = 8;
   localparam int unsigned ID_WIDTH = 7;
   localparam int unsigned HISTORY_WIDTH = 24;

   localparam logic [7:0] SYNC_FILL = 8'hff;
   localparam logic [7:0] SYNC_LAST = 8'h7f;
   localparam logic [HISTORY_WIDTH-1:0] SYNC_HISTORY = 24'hffffff;

   localparam logic [POS_WIDTH-1:0] SYNC_CHECK_POS = 4'd3;
   localparam logic [POS_WIDTH-1:0] LAST_PAYLOAD_POS = 4'd14;
   localparam logic [POS_WIDTH-1:0] AUX_POS = 4'd15;

   localparam logic [ID_WIDTH-1:0] NO_SOURCE = 7'd0;

   localparam int unsigned FRAME_QUEUE_DEPTH = 2;
   localparam int unsigned RESULT_QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_WIDTH = 1;
   localparam int unsigned QUEUE_COUNT_WIDTH = 2;

   typedef struct packed {
      logic                            clear;
      logic [AUX_WIDTH-1:0]            aux;
      logic [PAYLOAD_BYTES-1:0][7:0]   payload;
   } tfd_frame_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] source_id;
      logic [7:0]          data_byte;
      logic                last_of_frame;
   } tfd_result_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } tfd_back_state_type;

endpackage

`default_nettype wire

// ===== src/tfd_front.sv =====
// Front end: takes raw trace bytes, hunts for sync and collects 16-byte frames.
// Depends on tfd_pkg; hands finished frames to tfd_frame_queue.
`default_nettype none

module tfd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_raw_byte,
   input  logic                   req_buffer_end,
   output tfd_pkg::tfd_frame_type frame_word,
   output logic                   frame_push,
   input  logic                   frame_full
);
   import tfd_pkg::*;

   logic [7:0]               store_ff [PAYLOAD_BYTES];
   logic [POS_WIDTH-1:0]     pos_ff, pos_in;
   logic                     aligned_ff, aligned_in;
   logic [HISTORY_WIDTH-1:0] history_ff, history_in;
   logic                     pending_clear_ff, pending_clear_in;
   logic                     mode_ff;
   logic                     accept;
   logic                     hunting;
   logic                     store_we;
   logic                     sync_match;

   assign req_full = frame_full;
   assign accept   = req_push && !frame_full;
   assign hunting  = mode_ff && !aligned_ff;

   // A sync word at the head of a frame completes when the fourth byte is written.
   assign sync_match = (pos_ff == SYNC_CHECK_POS) && (store_ff[0] == SYNC_FILL) &&
                       (store_ff[1] == SYNC_FILL) && (store_ff[2] == SYNC_FILL) &&
                       (req_raw_byte == SYNC_LAST);

   always_comb begin
      pos_in           = pos_ff;
      aligned_in       = aligned_ff;
      history_in       = history_ff;
      pending_clear_in = pending_clear_ff;
      store_we         = 1'b0;
      frame_push       = 1'b0;
      if (accept) begin
         if (hunting) begin
            if ((history_ff == SYNC_HISTORY) && (req_raw_byte == SYNC_LAST)) begin
               aligned_in = 1'b1;
               pos_in     = '0;
            end
         end else if (pos_ff != AUX_POS) begin
            store_we = 1'b1;
            pos_in   = sync_match ? '0 : pos_ff + 1'b1;
         end else begin
            frame_push       = 1'b1;
            pos_in           = '0;
            pending_clear_in = 1'b0;
         end
         history_in = {history_ff[HISTORY_WIDTH-9:0], req_raw_byte};
         if (req_buffer_end) begin
            pos_in           = '0;
            aligned_in       = 1'b0;
            history_in       = '0;
            pending_clear_in = 1'b1;
         end
      end
   end

   always_comb begin
      frame_word.clear = pending_clear_ff;
      frame_word.aux   = req_raw_byte;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         frame_word.payload[i] = store_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         aligned_ff       <= 1'b0;
         history_ff       <= '0;
         pending_clear_ff <= 1'b0;
         mode_ff          <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         aligned_ff       <= aligned_in;
         history_ff       <= history_in;
         pending_clear_ff <= pending_clear_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[pos_ff] <= req_raw_byte;
      end
   end

endmodule

`default_nettype wire

// ===== src/tfd_frame_queue.sv =====
// Two-entry queue of complete frames between the front and the back end.
// Depends on tfd_pkg for the frame type.
`default_nettype none

module tfd_frame_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tfd_pkg::tfd_frame_type push_word,
   output logic                   full,
   input  logic                   pop,
   output tfd_pkg::tfd_frame_type head_word,
   output logic                   head_valid
);
   import tfd_pkg::*;

   tfd_frame_type                entry_ff [FRAME_QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff;
   logic                         do_push, do_pop;

   assign full       = (count_ff == QUEUE_COUNT_WIDTH'(FRAME_QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_word  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ===== src/tfd_result_queue.sv =====
// Two-entry output queue holding decoded words until the consumer pops them.
// Depends on tfd_pkg for the result type.
`default_nettype none

module tfd_result_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tfd_pkg::tfd_result_type push_word,
   output logic                    space,
   input  logic                    pop,
   output tfd_pkg::tfd_result_type head_word,
   output logic                    empty
);
   import tfd_pkg::*;

   tfd_result_type               entry_ff [RESULT_QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff;
   logic                         do_push, do_pop;

   assign space     = (count_ff != QUEUE_COUNT_WIDTH'(RESULT_QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = entry_ff[rd_ptr_ff];
   assign do_push   = push && space;
   assign do_pop    = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ===== src/tfd_back.sv =====
// Back end: walks a frame a byte per cycle unless output is full; tags data with IDs.
// Depends on tfd_pkg; reads tfd_frame_queue and writes tfd_result_queue.
`default_nettype none

module tfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tfd_pkg::tfd_frame_type  frame_word,
   input  logic                    frame_valid,
   output logic                    frame_pop,
   output tfd_pkg::tfd_result_type res_word,
   output logic                    res_push,
   input  logic                    res_space
);
   import tfd_pkg::*;

   tfd_back_state_type            state_ff, state_in;
   logic [PAYLOAD_BYTES-1:0][7:0] payload_ff, payload_in;
   logic [AUX_WIDTH-1:0]          aux_ff, aux_in;
   logic [POS_WIDTH-1:0]          pos_ff, pos_in;
   logic [ID_WIDTH-1:0]           cur_ff, cur_in;
   logic [ID_WIDTH-1:0]           prev_ff, prev_in;
   logic                          stopped_ff, stopped_in;
   logic                          prev_lsb_ff, prev_lsb_in;
   logic                          held_valid_ff, held_valid_in;
   logic [ID_WIDTH-1:0]           held_src_ff, held_src_in;
   logic [7:0]                    held_data_ff, held_data_in;

   logic [7:0]          byte_now;
   logic                aux_bit;
   logic                is_id;
   logic [ID_WIDTH-1:0] step_src;
   logic [7:0]          step_data;
   logic                step_valid;
   logic                stall;
   logic                eff_stopped;

   assign byte_now = payload_ff[0];
   assign aux_bit  = aux_ff[pos_ff[POS_WIDTH-1:1]];
   assign is_id    = !pos_ff[0] && byte_now[0];

   // Odd positions after an ID byte keep the previous owner when the aux bit is set.
   always_comb begin
      if (pos_ff[0]) begin
         step_src  = (prev_lsb_ff && aux_bit) ? prev_ff : cur_ff;
         step_data = byte_now;
      end else begin
         step_src  = cur_ff;
         step_data = {byte_now[7:1], aux_bit};
      end
   end

   assign step_valid  = !is_id && (step_src != NO_SOURCE);
   assign stall       = step_valid && held_valid_ff && !res_space;
   assign eff_stopped = frame_word.clear ? 1'b0 : stopped_ff;

   always_comb begin
      state_in      = state_ff;
      payload_in    = payload_ff;
      aux_in        = aux_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      stopped_in    = stopped_ff;
      prev_lsb_in   = prev_lsb_ff;
      held_valid_in = held_valid_ff;
      held_src_in   = held_src_ff;
      held_data_in  = held_data_ff;
      frame_pop     = 1'b0;
      res_push      = 1'b0;
      res_word.source_id     = held_src_ff;
      res_word.data_byte     = held_data_ff;
      res_word.last_of_frame = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            // The word still held from the finished frame is its last one.
            res_word.last_of_frame = 1'b1;
            if (held_valid_ff && res_space) begin
               res_push      = 1'b1;
               held_valid_in = 1'b0;
            end
            if (frame_valid && (!held_valid_ff || res_space)) begin
               frame_pop = 1'b1;
               if (frame_word.clear) begin
                  cur_in     = NO_SOURCE;
                  prev_in    = NO_SOURCE;
                  stopped_in = 1'b0;
               end
               if (!eff_stopped) begin
                  payload_in  = frame_word.payload;
                  aux_in      = frame_word.aux;
                  pos_in      = '0;
                  prev_lsb_in = 1'b0;
                  state_in    = BACK_RUN;
               end
            end
         end
         BACK_RUN: begin
            if (!stall) begin
               payload_in  = payload_ff >> 8;
               pos_in      = pos_ff + 1'b1;
               prev_lsb_in = byte_now[0];
               if (pos_ff == LAST_PAYLOAD_POS) begin
                  state_in = BACK_IDLE;
               end
               if (is_id) begin
                  if (byte_now[7:1] == NO_SOURCE) begin
                     stopped_in = 1'b1;
                     state_in   = BACK_IDLE;
                  end else begin
                     prev_in = cur_ff;
                     cur_in  = byte_now[7:1];
                  end
               end else if (step_valid) begin
                  res_push      = held_valid_ff;
                  held_valid_in = 1'b1;
                  held_src_in   = step_src;
                  held_data_in  = step_data;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         pos_ff        <= '0;
         cur_ff        <= NO_SOURCE;
         prev_ff       <= NO_SOURCE;
         stopped_ff    <= 1'b0;
         prev_lsb_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         cur_ff        <= cur_in;
         prev_ff       <= prev_in;
         stopped_ff    <= stopped_in;
         prev_lsb_ff   <= prev_lsb_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff   <= payload_in;
      aux_ff       <= aux_in;
      held_src_ff  <= held_src_in;
      held_data_ff <= held_data_in;
   end

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_RUN |-> pos_ff <= LAST_PAYLOAD_POS)
      else $error("back end position ran past the payload");

   a_push_has_space: assert property (@(posedge clock) disable iff (reset)
      res_push |-> res_space)
      else $error("result pushed into a full queue");

   a_push_has_source: assert property (@(posedge clock) disable iff (reset)
      res_push |-> res_word.source_id != NO_SOURCE)
      else $error("result pushed without a source");

   a_run_not_stopped: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_RUN |-> !stopped_ff)
      else $error("frame decoded after a null ID");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      frame_pop |-> state_ff == BACK_IDLE && frame_valid)
      else $error("frame popped while decoding");
`endif

endmodule

`default_nettype wire

// ===== src/trace_frame_deformatter.sv =====
// Top level of the trace frame deformatter.
// Depends on tfd_pkg, tfd_front, tfd_frame_queue, tfd_back and tfd_result_queue.
//
// Usage: raw trace buffer bytes enter on the request side, one word per
// cycle, with req_buffer_end marking the last byte of a buffer. A word is
// taken when req_push is high and req_full is low. Decoded words leave on
// the response side: while rsp_empty is low the oldest word is on the rsp_
// ports, and it is taken when rsp_pop is high. rsp_last_of_frame marks the
// final word that a frame produces.
// The front end collects each 16-byte frame in registers and hands it to a
// two-frame queue once its auxiliary byte arrives. The back end loads each
// frame and then walks its payload bytes in order, which keeps pace with
// the shortest frame spacing, so a steady stream of one byte per cycle is
// taken without stalls while the receiver keeps popping.
// If the receiver stops popping, the result queue fills, the back end holds,
// the frame queue fills and req_full rises; nothing is lost.
// Reset clears all control state and the unaligned mode register; no
// clearing pass is needed, so words are taken right after reset.
`default_nettype none

module trace_frame_deformatter (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_raw_byte,
   input  logic       req_buffer_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_source_id,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_of_frame
);
   import tfd_pkg::*;

   tfd_frame_type  front_frame;
   logic           front_push;
   logic           queue_full;
   tfd_frame_type  head_frame;
   logic           head_valid;
   logic           back_pop;
   tfd_result_type back_result;
   logic           back_push;
   logic           result_space;
   tfd_result_type out_result;

   // Sync hunting and frame collection.
   tfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_raw_byte     (req_raw_byte),
      .req_buffer_end   (req_buffer_end),
      .frame_word       (front_frame),
      .frame_push       (front_push),
      .frame_full       (queue_full)
   );

   // Complete frames wait here so the front can keep taking bytes.
   tfd_frame_queue u_frame_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_word  (front_frame),
      .full       (queue_full),
      .pop        (back_pop),
      .head_word  (head_frame),
      .head_valid (head_valid)
   );

   // Demultiplexing of a frame, a payload byte per cycle unless output is full.
   tfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_word  (head_frame),
      .frame_valid (head_valid),
      .frame_pop   (back_pop),
      .res_word    (back_result),
      .res_push    (back_push),
      .res_space   (result_space)
   );

   // Output queue that decouples the receiver from the back end.
   tfd_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_word (back_result),
      .space     (result_space),
      .pop       (rsp_pop),
      .head_word (out_result),
      .empty     (rsp_empty)
   );

   assign rsp_source_id     = out_result.source_id;
   assign rsp_data_byte     = out_result.data_byte;
   assign rsp_last_of_frame = out_result.last_of_frame;

endmodule

`default_nettype wire
